### rtl/dpsc_pkg.sv
// Shared types, constants and the duty table for the dual pulse sound channels.
`timescale 1ns / 1ps

package dpsc_pkg;

    localparam int CMD_QUEUE_DEPTH = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    localparam int STEP_W = 21;
    localparam logic [STEP_W-1:0] FULL_SCALE = 21'd1048576;
    localparam logic [STEP_W-1:0] STEP_RESET = 21'd44100;
    localparam logic [10:0] PERIOD_MAX = 11'h7FF;
    localparam logic [7:0] DAC_MASK = 8'b1111_1000;
    localparam logic [6:0] LENGTH_FULL = 7'd64;

    localparam logic [5:0] OFF_CTRL = 6'h26;

    localparam logic [1:0] IDX_LEN = 2'd0;
    localparam logic [1:0] IDX_ENV = 2'd1;
    localparam logic [1:0] IDX_LO = 2'd2;
    localparam logic [1:0] IDX_HI = 2'd3;

    // Bit n of a row is the output at duty position n.
    localparam logic [3:0][7:0] DUTY_TABLE = {
        8'b1000_0001,
        8'b0001_1110,
        8'b0111_1110,
        8'b0111_1111
    };

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_CHAN_WR,
        CMD_CTRL_WR,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        logic       action;
        logic [5:0] reg_offset;
        logic [7:0] write_data;
        logic       frame_step;
    } in_item_t;

    typedef struct packed {
        logic       sample_valid;
        logic [6:0] sample;
        logic       ch1_active;
        logic       ch2_active;
        logic       master_on;
    } out_item_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic       chan;
        logic [1:0] idx;
        logic [7:0] data;
        logic       frame;
    } cmd_t;

endpackage

### rtl/dpsc_fifo.sv
// Small generic request queue built from flip-flops.
`timescale 1ns / 1ps

module dpsc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] mem_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/dpsc_front.sv
// Front end: decodes each request into a command and queues it for the back end.
`timescale 1ns / 1ps

module dpsc_front #(
    parameter int DEPTH = dpsc_pkg::CMD_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dpsc_pkg::in_item_t in_item,
    output logic               full,
    input  logic               cmd_pop,
    output dpsc_pkg::cmd_t     cmd,
    output logic               cmd_empty
);

    import dpsc_pkg::*;

    cmd_t cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_bits;

    always_comb
    begin
        cmd_in.kind = CMD_NOP;
        cmd_in.chan = 1'b0;
        cmd_in.idx = 2'd0;
        cmd_in.data = in_item.write_data;
        cmd_in.frame = in_item.frame_step;
        if (!in_item.action)
        begin
            cmd_in.kind = CMD_TICK;
        end
        else if (in_item.reg_offset inside {[6'h11:6'h14]})
        begin
            cmd_in.kind = CMD_CHAN_WR;
            cmd_in.chan = 1'b0;
            cmd_in.idx = 2'(in_item.reg_offset - 6'h11);
        end
        else if (in_item.reg_offset inside {[6'h16:6'h19]})
        begin
            cmd_in.kind = CMD_CHAN_WR;
            cmd_in.chan = 1'b1;
            cmd_in.idx = 2'(in_item.reg_offset - 6'h16);
        end
        else if (in_item.reg_offset == OFF_CTRL)
        begin
            cmd_in.kind = CMD_CTRL_WR;
        end
    end

    dpsc_fifo #(
        .WIDTH($bits(cmd_t)),
        .DEPTH(DEPTH)
    ) u_cmd_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .wdata(cmd_in),
        .full(full),
        .pop(cmd_pop),
        .rdata(cmd_bits),
        .empty(cmd_empty)
    );

    assign cmd = cmd_t'(cmd_bits);

endmodule

### rtl/dpsc_back.sv
// Back end: channel state, mixer and sample accumulator, one command per cycle while the result queue has room.
`timescale 1ns / 1ps

module dpsc_back #(
    parameter int DEPTH = dpsc_pkg::RES_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [20:0]         cfg_data,
    input  dpsc_pkg::cmd_t      cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    output dpsc_pkg::out_item_t out_item,
    output logic                empty,
    input  logic                pop
);

    import dpsc_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [1:0][3:0][7:0] regs_reg, regs_next;
    logic [1:0] en_reg, en_next;
    logic master_reg, master_next;
    logic [1:0] trig_reg, trig_next;
    logic [1:0][10:0] period_reg, period_next;
    logic [1:0][2:0] duty_reg, duty_next;
    logic [1:0][3:0] vol_reg, vol_next;
    logic [1:0][2:0] envc_reg, envc_next;
    logic [1:0][6:0] len_reg, len_next;
    logic [2:0] frame_reg, frame_next;
    logic [STEP_W-1:0] accum_reg, accum_next;

    logic res_full;
    logic exec;
    out_item_t res;
    logic [$bits(out_item_t)-1:0] res_bits;

    assign exec = !cmd_empty && !res_full;
    assign cmd_pop = exec;

    always_comb
    begin : exec_logic
        logic [STEP_W-1:0] step;
        logic [STEP_W:0] sum;
        logic [3:0] lvl0, lvl1;
        logic [4:0] mix;
        logic [7:0] env_r, hi_r, len_r;
        logic skip_env;

        regs_next = regs_reg;
        en_next = en_reg;
        master_next = master_reg;
        trig_next = trig_reg;
        period_next = period_reg;
        duty_next = duty_reg;
        vol_next = vol_reg;
        envc_next = envc_reg;
        len_next = len_reg;
        frame_next = frame_reg;
        accum_next = accum_reg;
        res = '0;
        env_r = '0;
        hi_r = '0;
        len_r = '0;
        skip_env = 1'b0;

        step = (step_reg > FULL_SCALE) ? FULL_SCALE : step_reg;
        sum = {1'b0, accum_reg} + {1'b0, step};
        lvl0 = (en_reg[0] && DUTY_TABLE[regs_reg[0][IDX_LEN][7:6]][duty_reg[0]]) ?
               vol_reg[0] : 4'd0;
        lvl1 = (en_reg[1] && DUTY_TABLE[regs_reg[1][IDX_LEN][7:6]][duty_reg[1]]) ?
               vol_reg[1] : 4'd0;
        mix = {1'b0, lvl0} + {1'b0, lvl1};

        case (cmd.kind)
            CMD_TICK:
            begin
                if (sum >= {1'b0, FULL_SCALE})
                begin
                    res.sample_valid = 1'b1;
                    res.sample = {mix, 2'b00};
                    sum = sum - {1'b0, FULL_SCALE};
                end
                accum_next = sum[STEP_W-1:0];
                if (cmd.frame)
                begin
                    frame_next = frame_reg + 3'd1;
                end
                if (master_reg)
                begin
                    for (int c = 0; c < 2; c++)
                    begin
                        len_r = regs_reg[c][IDX_LEN];
                        env_r = regs_reg[c][IDX_ENV];
                        hi_r = regs_reg[c][IDX_HI];
                        skip_env = 1'b0;
                        if (trig_reg[c])
                        begin
                            trig_next[c] = 1'b0;
                            en_next[c] = 1'b1;
                            if (len_reg[c] == 7'd0)
                            begin
                                len_next[c] = LENGTH_FULL - {1'b0, len_r[5:0]};
                            end
                            period_next[c] = {hi_r[2:0], regs_reg[c][IDX_LO]};
                            envc_next[c] = env_r[2:0];
                            vol_next[c] = env_r[7:4];
                        end
                        if ((env_r & DAC_MASK) == 8'd0)
                        begin
                            en_next[c] = 1'b0;
                        end
                        if (en_next[c])
                        begin
                            if (period_next[c] == PERIOD_MAX)
                            begin
                                period_next[c] = {hi_r[2:0], regs_reg[c][IDX_LO]};
                                duty_next[c] = duty_next[c] + 3'd1;
                            end
                            else
                            begin
                                period_next[c] = period_next[c] + 11'd1;
                            end
                            if (cmd.frame)
                            begin
                                if (!frame_next[0] && len_next[c] != 7'd0 && hi_r[6])
                                begin
                                    len_next[c] = len_next[c] - 7'd1;
                                    if (len_next[c] == 7'd0)
                                    begin
                                        en_next[c] = 1'b0;
                                        skip_env = 1'b1;
                                    end
                                end
                                if (!skip_env && frame_next == 3'd0 && env_r[2:0] != 3'd0)
                                begin
                                    envc_next[c] = envc_next[c] - 3'd1;
                                    if (envc_next[c] == 3'd0)
                                    begin
                                        envc_next[c] = env_r[2:0];
                                        if (env_r[3])
                                        begin
                                            if (vol_next[c] != 4'd15)
                                            begin
                                                vol_next[c] = vol_next[c] + 4'd1;
                                            end
                                        end
                                        else if (vol_next[c] != 4'd0)
                                        begin
                                            vol_next[c] = vol_next[c] - 4'd1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
            end
            CMD_CHAN_WR:
            begin
                regs_next[cmd.chan][cmd.idx] = cmd.data;
                if (cmd.idx == IDX_HI && cmd.data[7])
                begin
                    trig_next[cmd.chan] = 1'b1;
                end
            end
            CMD_CTRL_WR:
            begin
                master_next = cmd.data[7];
            end
            default:
            begin
            end
        endcase

        res.ch1_active = en_next[0];
        res.ch2_active = en_next[1];
        res.master_on = master_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            regs_reg <= '0;
            en_reg <= '0;
            master_reg <= 1'b0;
            trig_reg <= '0;
            period_reg <= '0;
            duty_reg <= '0;
            vol_reg <= '0;
            envc_reg <= '0;
            len_reg <= '0;
            frame_reg <= '0;
            accum_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                step_reg <= cfg_data;
            end
            if (exec)
            begin
                regs_reg <= regs_next;
                en_reg <= en_next;
                master_reg <= master_next;
                trig_reg <= trig_next;
                period_reg <= period_next;
                duty_reg <= duty_next;
                vol_reg <= vol_next;
                envc_reg <= envc_next;
                len_reg <= len_next;
                frame_reg <= frame_next;
                accum_reg <= accum_next;
            end
        end
    end

    dpsc_fifo #(
        .WIDTH($bits(out_item_t)),
        .DEPTH(DEPTH)
    ) u_res_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(exec),
        .wdata(res),
        .full(res_full),
        .pop(pop),
        .rdata(res_bits),
        .empty(empty)
    );

    assign out_item = out_item_t'(res_bits);

endmodule

### rtl/dual_pulse_sound_channels.sv
// Top level of the dual pulse sound channels with mixer.
`timescale 1ns / 1ps

// Every request is either a sound register write or one machine tick, and each
// one gives exactly one result in order. The block takes one request per clock
// cycle while its queues have room; a request is registered in the command queue
// and its result in the result queue before it can be popped. The rate is set by
// the back end, which carries out the full update of both channels, the mixer and
// the sample accumulator for one request combinationally. The front end decodes
// register offsets into a short queue, and results wait in a second queue.
// Write sample_step through cfg_we and cfg_data only while the block is idle.

module dual_pulse_sound_channels #(
    parameter int CMD_DEPTH = dpsc_pkg::CMD_QUEUE_DEPTH,
    parameter int RES_DEPTH = dpsc_pkg::RES_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dpsc_pkg::in_item_t  in_item,
    output logic                full,
    output dpsc_pkg::out_item_t out_item,
    output logic                empty,
    input  logic                pop,
    input  logic                cfg_we,
    input  logic [20:0]         cfg_data
);

    import dpsc_pkg::*;

    cmd_t cmd;
    logic cmd_empty;
    logic cmd_pop;

    dpsc_front #(
        .DEPTH(CMD_DEPTH)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .in_item(in_item),
        .full(full),
        .cmd_pop(cmd_pop),
        .cmd(cmd),
        .cmd_empty(cmd_empty)
    );

    dpsc_back #(
        .DEPTH(RES_DEPTH)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data),
        .cmd(cmd),
        .cmd_empty(cmd_empty),
        .cmd_pop(cmd_pop),
        .out_item(out_item),
        .empty(empty),
        .pop(pop)
    );

endmodule

### tb/tb_dual_pulse_sound_channels.sv
// Self-checking testbench for the dual pulse sound channels with mixer.
`timescale 1ns / 1ps

module tb_dual_pulse_sound_channels;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic [5:0] OFF_CH1 = 6'h11;
    localparam logic [5:0] OFF_CH2 = 6'h16;
    localparam logic [5:0] OFF_MASTER = 6'h26;
    localparam logic [5:0] OFF_UNUSED = 6'h15;
    localparam logic [5:0] OFF_TOP = 6'h3F;

    localparam logic [5:0] REG_LEN = 6'd0;
    localparam logic [5:0] REG_ENV = 6'd1;
    localparam logic [5:0] REG_LO = 6'd2;
    localparam logic [5:0] REG_HI = 6'd3;

    localparam logic [20:0] STEP_FULL = 21'd1048576;
    localparam logic [20:0] STEP_MAX = 21'h1FFFFF;
    localparam logic [10:0] PERIOD_TOP = 11'h7FF;
    localparam logic [7:0] DAC_BITS = 8'hF8;
    localparam logic [6:0] LEN_RELOAD = 7'd64;

    localparam int HOLD_CYCLES = 150;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    dpsc_pkg::in_item_t in_item = '0;
    logic full;
    dpsc_pkg::out_item_t out_item;
    logic empty;
    logic pop = 1'b0;
    logic cfg_we = 1'b0;
    logic [20:0] cfg_data = '0;

    dual_pulse_sound_channels u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_item  (in_item),
        .full     (full),
        .out_item (out_item),
        .empty    (empty),
        .pop      (pop),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted sound state.
    logic [7:0] regs_q [8];
    logic [7:0] ctl_q;
    logic trig_q [2];
    logic [10:0] per_q [2];
    logic [2:0] duty_pos_q [2];
    logic [3:0] vol_q [2];
    logic [2:0] env_cnt_q [2];
    logic [6:0] len_q [2];
    logic [2:0] frame_q;
    logic [20:0] accum_q;
    logic [20:0] step_q;

    dpsc_pkg::in_item_t pending_requests [$];
    dpsc_pkg::out_item_t expected_results [$];

    int errors = 0;
    int n_ticks = 0;
    int n_writes = 0;
    int n_samples = 0;
    int n_triggers = 0;
    int cycle_count = 0;
    bit quiet = 1'b0;
    int hold_ask = 0;
    int hold_done = 0;
    int hold_left = 0;
    int tx_gap = 0;
    int rx_gap = 0;

    task automatic reset_sound_model();
        for (int i = 0; i < 8; i++)
        begin
            regs_q[i] = '0;
        end
        for (int c = 0; c < 2; c++)
        begin
            trig_q[c] = 1'b0;
            per_q[c] = '0;
            duty_pos_q[c] = '0;
            vol_q[c] = '0;
            env_cnt_q[c] = '0;
            len_q[c] = '0;
        end
        ctl_q = '0;
        frame_q = '0;
        accum_q = '0;
        step_q = 21'd44100;
    endtask

    function automatic logic duty_bit(logic [1:0] duty, logic [2:0] pos);
        logic [7:0] wave;
        case (duty)
            2'd0: wave = 8'b0111_1111;
            2'd1: wave = 8'b0111_1110;
            2'd2: wave = 8'b0001_1110;
            default: wave = 8'b1000_0001;
        endcase
        return wave[pos];
    endfunction

    function automatic int unsigned chan_level(int c);
        if (!ctl_q[c])
        begin
            return 0;
        end
        return 32'(duty_bit(regs_q[c * 4 + REG_LEN][7:6], duty_pos_q[c])) * 32'(vol_q[c]);
    endfunction

    task automatic model_write(logic [5:0] off, logic [7:0] d);
        int idx;
        idx = -1;
        if (off >= OFF_CH1 && off <= OFF_CH1 + 3)
        begin
            idx = int'(off - OFF_CH1);
        end
        else if (off >= OFF_CH2 && off <= OFF_CH2 + 3)
        begin
            idx = int'(off - OFF_CH2) + 4;
        end
        if (idx >= 0)
        begin
            regs_q[idx] = d;
            if ((idx % 4) == REG_HI && d[7])
            begin
                trig_q[idx / 4] = 1'b1;
                n_triggers++;
            end
        end
        else if (off == OFF_MASTER)
        begin
            ctl_q[7] = d[7];
        end
    endtask

    task automatic model_chan_tick(int c, logic frame);
        logic [7:0] len_r;
        logic [7:0] env_r;
        logic [7:0] hi_r;
        logic [10:0] reload;
        len_r = regs_q[c * 4 + REG_LEN];
        env_r = regs_q[c * 4 + REG_ENV];
        hi_r = regs_q[c * 4 + REG_HI];
        reload = {hi_r[2:0], regs_q[c * 4 + REG_LO]};
        if (trig_q[c])
        begin
            trig_q[c] = 1'b0;
            ctl_q[c] = 1'b1;
            if (len_q[c] == 0)
            begin
                len_q[c] = LEN_RELOAD - {1'b0, len_r[5:0]};
            end
            per_q[c] = reload;
            env_cnt_q[c] = env_r[2:0];
            vol_q[c] = env_r[7:4];
        end
        if ((env_r & DAC_BITS) == 0)
        begin
            ctl_q[c] = 1'b0;
        end
        if (!ctl_q[c])
        begin
            return;
        end
        if (per_q[c] == PERIOD_TOP)
        begin
            per_q[c] = reload;
            duty_pos_q[c] = duty_pos_q[c] + 3'd1;
        end
        else
        begin
            per_q[c] = per_q[c] + 11'd1;
        end
        if (!frame)
        begin
            return;
        end
        if (!frame_q[0] && len_q[c] != 0 && hi_r[6])
        begin
            len_q[c] = len_q[c] - 7'd1;
            if (len_q[c] == 0)
            begin
                ctl_q[c] = 1'b0;
                return;
            end
        end
        if (frame_q == 0 && env_r[2:0] != 0)
        begin
            env_cnt_q[c] = env_cnt_q[c] - 3'd1;
            if (env_cnt_q[c] == 0)
            begin
                env_cnt_q[c] = env_r[2:0];
                if (env_r[3])
                begin
                    if (vol_q[c] < 4'd15)
                    begin
                        vol_q[c] = vol_q[c] + 4'd1;
                    end
                end
                else if (vol_q[c] > 4'd0)
                begin
                    vol_q[c] = vol_q[c] - 4'd1;
                end
            end
        end
    endtask

    task automatic predict_sound(input dpsc_pkg::in_item_t it,
                                 output dpsc_pkg::out_item_t r);
        logic [21:0] sum;
        logic [20:0] step;
        r = '0;
        if (it.action == ACT_WRITE)
        begin
            n_writes++;
            model_write(it.reg_offset, it.write_data);
        end
        else
        begin
            n_ticks++;
            step = (step_q > STEP_FULL) ? STEP_FULL : step_q;
            sum = {1'b0, accum_q} + {1'b0, step};
            if (sum >= {1'b0, STEP_FULL})
            begin
                r.sample_valid = 1'b1;
                r.sample = 7'((chan_level(0) + chan_level(1)) * 4);
                sum = sum - {1'b0, STEP_FULL};
                n_samples++;
            end
            accum_q = sum[20:0];
            if (it.frame_step)
            begin
                frame_q = frame_q + 3'd1;
            end
            if (ctl_q[7])
            begin
                model_chan_tick(0, it.frame_step);
                model_chan_tick(1, it.frame_step);
            end
        end
        r.ch1_active = ctl_q[0];
        r.ch2_active = ctl_q[1];
        r.master_on = ctl_q[7];
    endtask

    task automatic check_field(string name, int unsigned exp, int unsigned act);
        if (exp != act)
        begin
            errors++;
            $display("ERROR %0t: %s expected %0d actual %0d", $time, name, exp, act);
        end
    endtask

    task automatic check_result(dpsc_pkg::out_item_t got);
        dpsc_pkg::out_item_t want;
        if (expected_results.size() == 0)
        begin
            errors++;
            $display("ERROR %0t: result with no request outstanding, actual %h", $time, got);
            return;
        end
        want = expected_results.pop_front();
        check_field("sample_valid", 32'(want.sample_valid), 32'(got.sample_valid));
        check_field("sample", 32'(want.sample), 32'(got.sample));
        check_field("ch1_active", 32'(want.ch1_active), 32'(got.ch1_active));
        check_field("ch2_active", 32'(want.ch2_active), 32'(got.ch2_active));
        check_field("master_on", 32'(want.master_on), 32'(got.master_on));
    endtask

    always @(posedge clk)
    begin : driver
        logic nxt_push;
        dpsc_pkg::in_item_t nxt_item;
        dpsc_pkg::out_item_t want;
        if (rst_n)
        begin
            nxt_push = push;
            nxt_item = in_item;
            if (push && !full)
            begin
                predict_sound(in_item, want);
                expected_results.push_back(want);
                nxt_push = 1'b0;
            end
            if (!nxt_push)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                end
                else if (pending_requests.size() > 0)
                begin
                    if (!quiet && $urandom_range(0, 5) == 0)
                    begin
                        tx_gap = $urandom_range(0, 4);
                    end
                    else
                    begin
                        nxt_push = 1'b1;
                        nxt_item = pending_requests.pop_front();
                    end
                end
            end
            push <= nxt_push;
            in_item <= nxt_item;
        end
    end

    always @(posedge clk)
    begin : monitor
        logic nxt_pop;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                check_result(out_item);
            end
            if (hold_done != hold_ask)
            begin
                hold_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                nxt_pop = 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                nxt_pop = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                rx_gap = $urandom_range(0, 4);
                nxt_pop = 1'b0;
            end
            else
            begin
                nxt_pop = 1'b1;
            end
            pop <= nxt_pop;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic add_item(logic act, logic [5:0] off, logic [7:0] d, logic fr);
        dpsc_pkg::in_item_t it;
        it.action = act;
        it.reg_offset = off;
        it.write_data = d;
        it.frame_step = fr;
        pending_requests.push_back(it);
    endtask

    task automatic add_tick(logic fr);
        add_item(ACT_TICK, 6'($urandom_range(0, 63)), 8'($urandom), fr);
    endtask

    task automatic add_write(logic [5:0] off, logic [7:0] d);
        add_item(ACT_WRITE, off, d, 1'($urandom));
    endtask

    task automatic add_voice_burst();
        logic [5:0] base;
        logic [7:0] env;
        logic [7:0] lo;
        logic [7:0] hi;
        int n;
        base = $urandom_range(0, 1) ? OFF_CH2 : OFF_CH1;
        if ($urandom_range(0, 3) == 0)
        begin
            add_write(OFF_MASTER, {1'b1, 7'($urandom)});
        end
        if ($urandom_range(0, 1) == 0)
        begin
            add_write(base + REG_LEN, 8'($urandom));
        end
        env = 8'($urandom);
        if ($urandom_range(0, 4) != 0 && (env & DAC_BITS) == 0)
        begin
            env[3] = 1'b1;
        end
        add_write(base + REG_ENV, env);
        lo = $urandom_range(0, 1) ? 8'($urandom_range(8'hE0, 8'hFF)) : 8'($urandom);
        add_write(base + REG_LO, lo);
        hi = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            hi[2:0] = 3'b111;
        end
        hi[7] = ($urandom_range(0, 4) != 0);
        add_write(base + REG_HI, hi);
        n = $urandom_range(8, 40);
        repeat (n)
        begin
            add_tick(1'($urandom));
        end
    endtask

    task automatic add_random_mix(int n);
        int pick;
        int k;
        while (pending_requests.size() < n)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 6)
            begin
                add_voice_burst();
            end
            else if (pick == 7)
            begin
                add_write(OFF_MASTER, 8'($urandom));
            end
            else
            begin
                k = $urandom_range(2, 6);
                repeat (k)
                begin
                    add_item(1'($urandom), 6'($urandom_range(0, 63)), 8'($urandom),
                             1'($urandom));
                end
            end
        end
    endtask

    task automatic add_directed();
        add_tick(1'b1);
        add_write(OFF_MASTER, 8'hFF);
        add_write(OFF_CH1 + REG_LEN, 8'hFF);
        add_write(OFF_CH1 + REG_ENV, 8'h00);
        add_write(OFF_CH1 + REG_HI, 8'hC7);
        add_tick(1'b0);
        add_write(OFF_CH1 + REG_ENV, 8'hF9);
        add_write(OFF_CH1 + REG_LO, 8'hFF);
        add_write(OFF_CH1 + REG_HI, 8'hC7);
        add_tick(1'b0);
        add_tick(1'b1);
        add_write(OFF_CH2 + REG_LEN, 8'h3F);
        add_write(OFF_CH2 + REG_ENV, 8'h08);
        add_write(OFF_CH2 + REG_HI, 8'h87);
        add_write(OFF_MASTER, 8'h00);
        add_tick(1'b1);
        add_write(OFF_MASTER, 8'h80);
        add_tick(1'b1);
        add_write(OFF_CH2 + REG_ENV, 8'h0B);
        add_write(OFF_CH2 + REG_LO, 8'hFF);
        repeat (4)
        begin
            add_tick(1'b1);
        end
        add_write(OFF_UNUSED, 8'hFF);
        add_write(OFF_TOP, 8'hFF);
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_requests.size() != 0 || push || expected_results.size() != 0);
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_sample_step(logic [20:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        step_q = value;
    endtask

    initial
    begin
        reset_sound_model();
        repeat (12)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;

        add_directed();
        add_random_mix(300);

        write_sample_step(STEP_FULL);
        add_random_mix(300);

        write_sample_step(STEP_MAX);
        add_random_mix(250);

        write_sample_step(21'd1);
        add_random_mix(200);

        write_sample_step(21'($urandom_range(1, 1048576)));
        hold_ask++;
        add_random_mix(350);

        quiet = 1'b1;
        write_sample_step(21'd524288);
        add_random_mix(300);

        wait_drained();
        $display("Covered %0d requests: %0d ticks, %0d register writes, %0d triggers,",
                 n_ticks + n_writes, n_ticks, n_writes, n_triggers);
        $display("%0d mixed samples over six sample step settings.", n_samples);
        if (errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
